/* hdl/nsr_pkg.sv */
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, microcode encoding and control store of the Newton
// square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int unsigned NSR_W      = 64;
  localparam int unsigned NSR_ROOT_W = 49;
  localparam int unsigned NSR_TOL_W  = 33;
  localparam logic [NSR_TOL_W-1:0] NSR_TOL_RESET = 33'd429;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_CHECK   = 4'd1;
  localparam step_t STEP_ROUND   = 4'd2;
  localparam step_t STEP_WAIT    = 4'd3;
  localparam step_t STEP_UPDATE  = 4'd4;
  localparam step_t STEP_DIFF    = 4'd5;
  localparam step_t STEP_TEST    = 4'd6;
  localparam step_t STEP_ADVANCE = 4'd7;
  localparam step_t STEP_CAP     = 4'd8;
  localparam step_t STEP_EMIT    = 4'd9;

  // Datapath operation of a step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLASSIFY,
    OP_DIV_START,
    OP_UPDATE,
    OP_DIFF,
    OP_ADVANCE,
    OP_CAP,
    OP_EMIT
  } op_e;

  // Jump condition of a step.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_IN_VALID,
    COND_SPECIAL,
    COND_DIV_DONE,
    COND_CONVERGED,
    COND_MORE_ROUNDS,
    COND_OUT_FREE
  } cond_e;

  // One control word: operation, jump condition, jump target, and whether
  // the step repeats itself while the condition is false.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
    logic  hold;
  } ctrl_t;

  // Flags that the datapath reports to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic special;
    logic div_done;
    logic converged;
    logic more_rounds;
    logic out_free;
  } status_t;

  function automatic ctrl_t nsr_rom(input step_t step);
    ctrl_t w;
    w = '{op: OP_NOP, cond: COND_NEVER, target: STEP_IDLE, hold: 1'b0};
    unique case (step)
      STEP_IDLE:    w = '{op: OP_LOAD,      cond: COND_IN_VALID,
                          target: STEP_CHECK, hold: 1'b1};
      STEP_CHECK:   w = '{op: OP_CLASSIFY,  cond: COND_SPECIAL,
                          target: STEP_EMIT, hold: 1'b0};
      STEP_ROUND:   w = '{op: OP_DIV_START, cond: COND_NEVER,
                          target: STEP_IDLE, hold: 1'b0};
      STEP_WAIT:    w = '{op: OP_NOP,       cond: COND_DIV_DONE,
                          target: STEP_UPDATE, hold: 1'b1};
      STEP_UPDATE:  w = '{op: OP_UPDATE,    cond: COND_NEVER,
                          target: STEP_IDLE, hold: 1'b0};
      STEP_DIFF:    w = '{op: OP_DIFF,      cond: COND_NEVER,
                          target: STEP_IDLE, hold: 1'b0};
      STEP_TEST:    w = '{op: OP_NOP,       cond: COND_CONVERGED,
                          target: STEP_EMIT, hold: 1'b0};
      STEP_ADVANCE: w = '{op: OP_ADVANCE,   cond: COND_MORE_ROUNDS,
                          target: STEP_ROUND, hold: 1'b0};
      STEP_CAP:     w = '{op: OP_CAP,       cond: COND_NEVER,
                          target: STEP_IDLE, hold: 1'b0};
      STEP_EMIT:    w = '{op: OP_EMIT,      cond: COND_OUT_FREE,
                          target: STEP_IDLE, hold: 1'b1};
      default:      w = '{op: OP_NOP,       cond: COND_NEVER,
                          target: STEP_IDLE, hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

/* hdl/nsr_divider.sv */
// ----------------------------------------------------------------------------
// nsr_divider
// Restoring divider, one quotient bit per cycle, for a 128-bit numerator
// over a 64-bit divisor; saturates when the quotient cannot fit.
// ----------------------------------------------------------------------------
module nsr_divider
  import nsr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NSR_W-1:0] hi_i,
  input  logic [NSR_W-1:0] lo_i,
  input  logic [NSR_W-1:0] den_i,
  output logic             busy_o,
  output logic [NSR_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NSR_W);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NSR_W-1:0] rem_q, rem_d;
  logic [NSR_W-1:0] lo_q, lo_d;
  logic [NSR_W-1:0] den_q, den_d;
  logic [NSR_W-1:0] quot_q, quot_d;
  logic [NSR_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_q, lo_q[NSR_W-1]};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      if (den_i == '0 || hi_i >= den_i) begin
        quot_d = '1;
        busy_d = 1'b0;
      end else begin
        rem_d  = hi_i;
        lo_d   = lo_i;
        den_d  = den_i;
        quot_d = '0;
        cnt_d  = CntW'(NSR_W - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d  = ge ? (shifted[NSR_W-1:0] - den_q) : shifted[NSR_W-1:0];
      quot_d = {quot_q[NSR_W-2:0], ge};
      lo_d   = {lo_q[NSR_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

/* hdl/nsr_sequencer.sv */
// ----------------------------------------------------------------------------
// nsr_sequencer
// Step counter over the control store, with conditional jumps and holds.
// ----------------------------------------------------------------------------
module nsr_sequencer
  import nsr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  step_t pc_q, pc_d;
  ctrl_t ctrl;
  logic  taken;

  assign ctrl = nsr_rom(pc_q);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:       taken = 1'b0;
      COND_IN_VALID:    taken = status_i.in_valid;
      COND_SPECIAL:     taken = status_i.special;
      COND_DIV_DONE:    taken = status_i.div_done;
      COND_CONVERGED:   taken = status_i.converged;
      COND_MORE_ROUNDS: taken = status_i.more_rounds;
      COND_OUT_FREE:    taken = status_i.out_free;
      default:          taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_d = ctrl.target;
    end else if (ctrl.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

/* hdl/newton_square_root_top.sv */
// ----------------------------------------------------------------------------
// newton_square_root_top
// Fixed-point Newton-Raphson square root with a microcoded controller.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one signed fixed-point radicand per item in
// s_axis_tdata. The master stream returns one item per input: the unsigned
// root in m_axis_tdata and the invalid and not-converged flags in
// m_axis_tuser. The user must write the tolerance register through
// cfg_we_i and cfg_wdata_i only while the block is idle; the block itself
// does not enforce this. The register resets to 429 (about 1e-7).
// Each Newton round starts a restoring division in the round step, waits
// for it, then runs the update, diff, test and advance steps; an item runs
// at most MAX_ITER rounds. Negative, zero and unit inputs skip the rounds.
// One item is worked on at a time. A finished result waits in the output
// register; the next item is already accepted and computed meanwhile, and
// the controller holds in its emit step until the receiver takes the old
// result. Reset empties the output register and returns the controller to
// its idle step; no result is lost or repeated under any stall pattern.
// ----------------------------------------------------------------------------
module newton_square_root_top
  import nsr_pkg::*;
#(
  parameter int unsigned MAX_ITER  = 64,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: tolerance register.
  input  logic                 cfg_we_i,
  input  logic [NSR_TOL_W-1:0] cfg_wdata_i,
  // Input items. tdata: [63:0] value.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,
  // Result items. tdata: [48:0] root, [55:49] zero.
  // tuser: [0] invalid, [1] not_converged.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser
);

  localparam int unsigned IterW = $clog2(MAX_ITER + 1);
  localparam logic [NSR_W-1:0] One = NSR_W'(1) << FRAC_BITS;

  ctrl_t   ctrl;
  status_t status;

  logic [NSR_TOL_W-1:0] tol_q;
  logic [NSR_W-1:0]     num_q, guess_q, next_q, diff_q, res_q;
  logic                 inv_q, nc_q;
  logic [IterW-1:0]     iter_q;

  logic                  out_valid_q;
  logic [NSR_ROOT_W-1:0] out_root_q;
  logic                  out_inv_q, out_nc_q;

  logic             div_start, div_busy;
  logic [NSR_W-1:0] div_quot, div_hi, div_lo;
  logic [NSR_W-1:0] next_val;
  logic             out_free, in_take, emit;

  nsr_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // The radicand is scaled by 2^FRAC_BITS into a 128-bit numerator.
  assign div_hi    = num_q >> (NSR_W - FRAC_BITS);
  assign div_lo    = num_q << FRAC_BITS;
  assign div_start = (ctrl.op == OP_DIV_START);

  nsr_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (div_hi),
    .lo_i    (div_lo),
    .den_i   (guess_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // Average of guess and quotient, rounded down without a 65-bit sum.
  assign next_val = (guess_q >> 1) + (div_quot >> 1)
                  + NSR_W'(guess_q[0] & div_quot[0]);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (ctrl.op == OP_LOAD);
  assign in_take       = s_axis_tready && s_axis_tvalid;
  assign emit          = (ctrl.op == OP_EMIT) && out_free;

  assign status.in_valid    = s_axis_tvalid;
  assign status.special     = num_q[NSR_W-1] || (num_q == '0) || (num_q == One);
  assign status.div_done    = !div_busy;
  assign status.converged   = diff_q < NSR_W'(tol_q);
  assign status.more_rounds = iter_q != IterW'(MAX_ITER);
  assign status.out_free    = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= NSR_TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Working registers of the datapath, loaded when an item is taken and written by the step operations.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      num_q   <= s_axis_tdata;
      guess_q <= s_axis_tdata;
      iter_q  <= '0;
    end
    unique case (ctrl.op)
      OP_CLASSIFY: begin
        res_q <= num_q[NSR_W-1] ? '0 : num_q;
        inv_q <= num_q[NSR_W-1];
        nc_q  <= 1'b0;
      end
      OP_DIV_START: begin
        iter_q <= iter_q + 1'b1;
      end
      OP_UPDATE: begin
        next_q <= next_val;
        res_q  <= next_val;
      end
      OP_DIFF: begin
        diff_q <= (guess_q >= next_q) ? (guess_q - next_q) : (next_q - guess_q);
      end
      OP_ADVANCE: begin
        guess_q <= next_q;
      end
      OP_CAP: begin
        nc_q <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded in the emit step once the previous result left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_root_q <= (|res_q[NSR_W-1:NSR_ROOT_W]) ? '1 : res_q[NSR_ROOT_W-1:0];
      out_inv_q  <= inv_q;
      out_nc_q   <= nc_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_root_q};
  assign m_axis_tuser  = {out_nc_q, out_inv_q};

endmodule

/* tb/nsr_result_checker.sv */
// ----------------------------------------------------------------------------
// nsr_result_checker
// Watches the configuration port and both streams of the Newton square root
// block. It predicts the root and flags of every accepted radicand and
// compares each returned item with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module nsr_result_checker
  import nsr_pkg::*;
#(
  parameter int unsigned MAX_ITER  = 64,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [NSR_TOL_W-1:0] cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [55:0]          m_axis_tdata,
  input  logic [1:0]           m_axis_tuser,
  output int                   mismatches_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ROOT_MAX = (64'd1 << NSR_ROOT_W) - 64'd1;

  typedef struct packed {
    logic [NSR_ROOT_W-1:0] root;
    logic                  invalid;
    logic                  not_converged;
  } sqrt_result_t;

  logic [NSR_TOL_W-1:0] tolerance;
  sqrt_result_t         pending_roots [$];
  int                   result_count;

  // One Newton round: the mean of the guess and value / guess, both floored.
  // A quotient wider than 64 bits (or a zero guess) saturates to all ones.
  function automatic logic [63:0] newton_step(input logic [63:0] num, input logic [63:0] guess);
    logic [127:0] dividend;
    logic [63:0]  quot;
    dividend = {64'd0, num} << FRAC_BITS;
    if (guess == 64'd0 || dividend[127:64] >= guess) begin
      quot = '1;
    end else begin
      quot = 64'(dividend / {64'd0, guess});
    end
    return (guess >> 1) + (quot >> 1) + {63'd0, guess[0] & quot[0]};
  endfunction

  function automatic sqrt_result_t newton_root(input logic [63:0] num,
                                               input logic [NSR_TOL_W-1:0] tol);
    sqrt_result_t res;
    logic [63:0]  guess;
    logic [63:0]  next;
    logic [63:0]  diff;
    bit           done;
    res = '0;
    if (num[63]) begin
      res.invalid = 1'b1;
    end else if (num == 64'd0) begin
      res.root = '0;
    end else if (num == (64'd1 << FRAC_BITS)) begin
      res.root = num[NSR_ROOT_W-1:0];
    end else begin
      guess = num;
      next  = num;
      done  = 1'b0;
      for (int k = 0; k < MAX_ITER && !done; k++) begin
        next = newton_step(num, guess);
        diff = (guess >= next) ? guess - next : next - guess;
        if (diff < {31'd0, tol}) begin
          done = 1'b1;
        end else begin
          guess = next;
        end
      end
      res.not_converged = !done;
      res.root = (next > ROOT_MAX) ? ROOT_MAX[NSR_ROOT_W-1:0] : next[NSR_ROOT_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: result %0d, %s mismatch: got 0x%0h, expected 0x%0h",
             $time, result_count, field, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sqrt_result_t want;
    if (!rst_ni) begin
      tolerance = NSR_TOL_RESET;
      pending_roots.delete();
      result_count = 0;
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        tolerance = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_roots.push_back(newton_root(s_axis_tdata, tolerance));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_roots.size() == 0) begin
          report_mismatch("unexpected item", {8'd0, m_axis_tdata}, 64'd0);
        end else begin
          want = pending_roots.pop_front();
          if (m_axis_tdata[NSR_ROOT_W-1:0] !== want.root) begin
            report_mismatch("root", 64'(m_axis_tdata[NSR_ROOT_W-1:0]), 64'(want.root));
          end
          if (m_axis_tdata[55:NSR_ROOT_W] !== '0) begin
            report_mismatch("tdata padding", 64'(m_axis_tdata[55:NSR_ROOT_W]), 64'd0);
          end
          if (m_axis_tuser[0] !== want.invalid) begin
            report_mismatch("invalid", 64'(m_axis_tuser[0]), 64'(want.invalid));
          end
          if (m_axis_tuser[1] !== want.not_converged) begin
            report_mismatch("not_converged", 64'(m_axis_tuser[1]),
                            64'(want.not_converged));
          end
        end
        result_count++;
      end
      pending_o = pending_roots.size();
    end
  end

endmodule

/* tb/newton_square_root_top_tb.sv */
// ----------------------------------------------------------------------------
// newton_square_root_top_tb
// Drives radicands into the Newton square root block under several tolerance
// settings and random handshake gaps; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module newton_square_root_top_tb
  import nsr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ROUNDS  = 64;
  localparam int unsigned FRAC        = 32;
  // Long receiver hold-off, in cycles, used to back the block up.
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam logic [63:0] ONE_FIXED   = 64'd1 << FRAC;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [NSR_TOL_W-1:0] cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [55:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  int mismatches;
  int pending;

  // When set, the sender or the receiver runs without gaps for a stretch.
  bit steady_tx    = 1'b0;
  bit steady_rx    = 1'b0;
  // Asks the receiver to hold off for HOLD_CYCLES before its next item.
  bit hold_request = 1'b0;

  logic [63:0] corner_values [20];

  newton_square_root_top #(
    .MAX_ITER  (MAX_ROUNDS),
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  nsr_result_checker #(
    .MAX_ITER  (MAX_ROUNDS),
    .FRAC_BITS (FRAC)
  ) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Radicands for the random part. Most are non-negative with a random
  // magnitude, so that roots of every size show up; some are fully random
  // (half of them negative) and a few sit on or next to zero and one.
  function automatic logic [63:0] random_radicand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: begin
      end
      2: begin
        case ($urandom_range(0, 4))
          0: v = 64'd0;
          1: v = ONE_FIXED;
          2: v = ONE_FIXED + 64'd1;
          3: v = ONE_FIXED - 64'd1;
          default: v = 64'd1;
        endcase
      end
      default: begin
        v[63] = 1'b0;
        v = v >> $urandom_range(0, 62);
      end
    endcase
    return v;
  endfunction

  // Radicands that skip the Newton rounds: zero, one and negatives. They let
  // the block fill its output register and stall its input quickly.
  function automatic logic [63:0] quick_radicand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 2))
      0: v = 64'd0;
      1: v = ONE_FIXED;
      default: v[63] = 1'b1;
    endcase
    return v;
  endfunction

  // Offers one item after a random gap and returns at the rising edge where
  // it was accepted. With no gap, tvalid simply stays high for the next item.
  task automatic send_value(input logic [63:0] value);
    int gap;
    gap = steady_tx ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering items and waits until every predicted result has come
  // back. Each item gives exactly one result, so the block is idle then.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_tolerance(input logic [NSR_TOL_W-1:0] tol);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = tol;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Draws whether the next stretch of items runs with or without gaps.
  task automatic pick_pacing();
    steady_tx = ($urandom_range(0, 3) == 0);
    steady_rx = ($urandom_range(0, 3) == 0);
  endtask

  // One setting of the tolerance register followed by random items.
  task automatic run_phase(input logic [NSR_TOL_W-1:0] tol, input int count);
    wait_drained();
    write_tolerance(tol);
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        pick_pacing();
      end
      send_value(random_radicand());
    end
  endtask

  // Receiver: a random stall before each item, or none in steady stretches,
  // or the long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (steady_rx) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 6);
      end
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;

    // Zero, one, negatives, the extremes of the signed range, the smallest
    // step, values just around one and a few exact squares.
    corner_values = '{
      64'h0000_0000_0000_0000, 64'h0000_0001_0000_0000,
      64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
      64'h0000_0000_0000_0002, 64'h0000_0004_0000_0000,
      64'h0000_0002_0000_0000, 64'h0000_0000_8000_0000,
      64'h0000_0001_0000_0001, 64'h0000_0000_FFFF_FFFF,
      64'h4000_0000_0000_0000, 64'h5555_5555_5555_5555,
      64'h2AAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFE,
      64'h0001_0000_0000_0000, 64'h0000_0009_0000_0000,
      64'h0000_0000_0000_0100, 64'h7FFF_FFFF_0000_0000
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items under the reset tolerance.
    foreach (corner_values[i]) begin
      send_value(corner_values[i]);
    end

    // The widest tolerance the register holds, then one (exactly 1.0).
    run_phase('1, 12);
    run_phase(33'h1_0000_0000, 18);
    // A tolerance of one step: rounds that settle on two neighboring values
    // never meet it and run into the cap.
    run_phase(33'd1, 12);
    // Zero tolerance is never met, so every regular item hits the cap.
    // These cost MAX_ITER rounds each, so only a few are sent.
    run_phase(33'd0, 6);
    run_phase(33'($urandom_range(1, 1 << 20)), 40);
    run_phase(33'($urandom_range(1 << 20, 32'hFFFF_FFFF)), 20);
    run_phase(33'($urandom_range(2, 4096)), 40);

    // Back-pressure: the receiver holds off for a long stretch while quick
    // items keep coming, so the output register fills and the input stalls.
    run_phase(NSR_TOL_RESET, 0);
    hold_request = 1'b1;
    steady_tx = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_value(quick_radicand());
    end
    send_value(random_radicand());
    send_value(random_radicand());
    // The sender pauses here until every result has come back.
    wait_drained();
    for (int i = 0; i < 56; i++) begin
      if (i % 16 == 0) begin
        pick_pacing();
      end
      send_value(random_radicand());
    end

    wait_drained();
    // Keep the clock running a while longer, so a stray extra result would be seen.
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS newton_square_root_top");
    end else begin
      $display("FAIL newton_square_root_top");
    end
    $finish;
  end

  // Watchdog: far above the slowest correct run, with every item at the
  // round cap and the longest gaps and stalls on both sides.
  initial begin : watchdog
    #100ms;
    $display("FAIL newton_square_root_top");
    $finish;
  end

endmodule

/* filelist.f */
hdl/nsr_pkg.sv
hdl/nsr_divider.sv
hdl/nsr_sequencer.sv
hdl/newton_square_root_top.sv
tb/nsr_result_checker.sv
tb/newton_square_root_top_tb.sv
